>>> src/phase_field_interpolation_table_macros.svh
// Assertion macros for the phase field interpolation table.
`ifndef PHASE_FIELD_INTERPOLATION_TABLE_MACROS_SVH
`define PHASE_FIELD_INTERPOLATION_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define PFIT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfit assertion failed");
`define PFIT_ASSERT_ALW(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pfit assertion failed");
`else
`define PFIT_ASSERT_IMP(name, clk, rst, ante, cons)
`define PFIT_ASSERT_ALW(name, clk, rst, cond)
`endif
`endif

>>> src/pfit_pkg.sv
// Shared constants for the phase field interpolation table.
package pfit_pkg;

  localparam int IDX_W       = 13;
  localparam int VALUE_W     = 19;
  localparam int GRID_W      = 11;
  localparam int MODE_W      = 3;
  localparam int STEEP_W     = 16;
  localparam int OFFS_W      = 18;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam int GRID_MAX_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [GRID_W-1:0]  GRID_RST  = 11'd64;
  localparam logic [MODE_W-1:0]  MODE_RST  = 3'd1;
  localparam logic [STEEP_W-1:0] STEEP_RST = 16'd2560;
  localparam logic [OFFS_W-1:0]  OFFS_RST  = '0;

  localparam logic [CFG_IDX_W-1:0] REG_GRID   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEEP  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd3;

  localparam logic [MODE_W-1:0] MODE_TANH    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OFFSET  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUINTIC = 3'd4;
  localparam logic [MODE_W-1:0] MODE_IDENT2  = 3'd5;

  // exp(-a) datapath, Q31
  localparam int Q_FRAC   = 31;
  localparam int CAP_EXP  = 13;
  localparam int H_BASE   = 11;
  localparam int H_W      = 25;
  localparam int H2_W     = 19;
  localparam int H3_W     = 13;
  localparam int V_W      = 32;
  localparam int SQ_N     = 12;
  // floor(n/6) = (n * DIV6_MUL) >> DIV6_SH for n below 2^13
  localparam logic [15:0] DIV6_MUL = 16'd43691;
  localparam int DIV6_W   = 16;
  localparam int DIV6_SH  = 18;

  localparam int DIV_STEP = 4;

endpackage

>>> src/pfit_div.sv
// Pipelined restoring divider, STEP_N quotient bits per stage, with sideband.
module pfit_div #(
  parameter int NUM_W  = 29,
  parameter int DEN_W  = 11,
  parameter int SIDE_W = 1,
  parameter int STEP_N = pfit_pkg::DIV_STEP
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STAGES = (NUM_W + STEP_N - 1) / STEP_N;
  localparam int PAD_W  = STAGES * STEP_N;
  localparam int W      = DEN_W + PAD_W;

  // work word: remainder on top, dividend bits shifting out, quotient shifting in
  logic [W-1:0]      work [STAGES];
  logic [W-1:0]      nxt  [STAGES];
  logic [DEN_W-1:0]  dv   [STAGES];
  logic [SIDE_W-1:0] sd   [STAGES];
  logic              vld  [STAGES];

  function automatic logic [W-1:0] div_step(input logic [W-1:0] w_in,
                                            input logic [DEN_W-1:0] d);
    logic [W:0]     t;
    logic [DEN_W:0] hi;
    logic [W-1:0]   w;
    w = w_in;
    for (int b = 0; b < STEP_N; b++) begin
      t  = {w, 1'b0};
      hi = t[W:PAD_W];
      if (hi >= {1'b0, d}) begin
        hi   = hi - {1'b0, d};
        t[0] = 1'b1;
      end
      w = {hi[DEN_W-1:0], t[PAD_W-1:0]};
    end
    return w;
  endfunction

  always_comb begin
    nxt[0] = div_step(W'(num), den);
    for (int k = 1; k < STAGES; k++) begin
      nxt[k] = div_step(work[k-1], dv[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work[0] <= nxt[0];
      dv[0]   <= den;
      sd[0]   <= side;
      for (int k = 1; k < STAGES; k++) begin
        work[k] <= nxt[k];
        dv[k]   <= dv[k-1];
        sd[k]   <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quo       = work[STAGES-1][NUM_W-1:0];
  assign side_out  = sd[STAGES-1];

endmodule

>>> src/pfit_fn.sv
// Function pipeline: tanh step through exp(-a) and reciprocal, quintic in parallel.
module pfit_fn #(
  parameter int FRAC_BITS = pfit_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic signed [pfit_pkg::IDX_W+FRAC_BITS:0] x_in,
  input  logic [pfit_pkg::STEEP_W-1:0]             steep,
  output logic                                     out_valid,
  output logic signed [pfit_pkg::IDX_W+FRAC_BITS:0] x_out,
  output logic signed [FRAC_BITS+1:0]              qy_out,
  output logic [FRAC_BITS:0]                       tanh_out
);

  localparam int F    = FRAC_BITS;
  localparam int Q    = pfit_pkg::Q_FRAC;
  localparam int XW   = pfit_pkg::IDX_W + F + 1;
  localparam int UW   = F + 1;
  localparam int PW   = pfit_pkg::STEEP_W + 1 + UW;
  localparam int PLW  = F + 5;
  localparam int YQW  = UW + PLW;
  localparam int QYW  = F + 2;
  localparam int HW   = pfit_pkg::H_W;
  localparam int H2W  = pfit_pkg::H2_W;
  localparam int H3W  = pfit_pkg::H3_W;
  localparam int VW   = pfit_pkg::V_W;
  localparam int SQN  = pfit_pkg::SQ_N;
  localparam int D6W  = H3W + pfit_pkg::DIV6_W;
  localparam int N2W  = F + Q + 1;
  localparam int SDW  = 1 + XW + QYW;
  localparam int SH_R = (F >= pfit_pkg::H_BASE) ? F - pfit_pkg::H_BASE : 0;
  localparam int SH_L = (F >= pfit_pkg::H_BASE) ? 0 : pfit_pkg::H_BASE - F;

  localparam logic [UW:0]      ONE2    = (UW+1)'(1) << F;
  localparam logic [UW-1:0]    ONE_U   = UW'(1) << F;
  localparam logic [PW-1:0]    CAP     = PW'(1) << (pfit_pkg::CAP_EXP + F);
  localparam logic [2*UW:0]    HALF_2  = (2*UW+1)'(1) << (F - 1);
  localparam logic [YQW:0]     HALF_Y  = (YQW+1)'(1) << (F - 1);
  localparam logic [QYW-1:0]   HALF_Q  = QYW'(1) << (F - 1);
  localparam logic [PLW-1:0]   TEN_ONE = PLW'(10) << F;
  localparam logic [VW:0]      Q_ONE   = (VW+1)'(1) << Q;
  localparam logic [2*VW-1:0]  Q_RND   = (2*VW)'(1) << (Q - 1);
  localparam logic [N2W-1:0]   N2_TOP  = N2W'(1) << (F + Q);

  // stage 1
  logic          v1, b1;
  logic [XW-1:0] x1;
  logic [UW-1:0] u1, d1;
  // stage 2
  logic          v2, b2;
  logic [XW-1:0] x2;
  logic [UW-1:0] u2;
  logic [PW-1:0] p2;
  logic [2*UW-1:0] sqx2;
  // stage 3
  logic          v3, b3;
  logic [XW-1:0] x3;
  logic [UW-1:0] u3, x2v;
  logic [HW-1:0] h3r;
  // stage 4
  logic          v4, b4;
  logic [XW-1:0] x4;
  logic [HW-1:0] h4;
  logic [2*HW-1:0] hh4;
  logic [2*UW-1:0] x3q;
  logic [PLW-1:0]  poly4;
  // stage 5
  logic          v5, b5;
  logic [XW-1:0] x5;
  logic [HW-1:0] h5;
  logic [H2W-1:0] h2_5;
  logic [UW-1:0]  x3v;
  logic [PLW-1:0] poly5;
  // stage 6
  logic          v6, b6;
  logic [XW-1:0] x6;
  logic [HW-1:0] h6;
  logic [H2W-1:0] h2_6;
  logic [H3W-1:0] h3_6;
  logic [YQW-1:0] yq6;
  // squaring chain
  logic           sv_vld [SQN+1];
  logic [VW-1:0]  sv     [SQN+1];
  logic           sb     [SQN+1];
  logic [XW-1:0]  sx     [SQN+1];
  logic [QYW-1:0] sqy    [SQN+1];

  logic [UW-1:0]   ux;
  logic [UW:0]     twox, dd;
  logic            below;
  logic [PW-1:0]   pc, hs;
  logic [2*UW:0]   x2t, x3t;
  logic [PLW-1:0]  pl;
  logic [H2W+HW-1:0] h3p;
  logic [D6W-1:0]  d6;
  logic [VW:0]     vt;
  logic [YQW:0]    yt;
  logic [VW:0]     den2;
  logic [N2W-1:0]  num2;
  logic            dv_out;
  logic [N2W-1:0]  quo2;
  logic [SDW-1:0]  side2;
  logic [UW-1:0]   r;

  always_comb begin
    ux    = x_in[UW-1:0];
    twox  = {ux, 1'b0};
    below = twox < ONE2;
    dd    = below ? ONE2 - twox : twox - ONE2;
    pc    = (p2 > CAP) ? CAP : p2;
    hs    = (F >= pfit_pkg::H_BASE) ? (pc >> SH_R) : (pc << SH_L);
    x2t   = {1'b0, sqx2} + HALF_2;
    x3t   = {1'b0, x3q} + HALF_2;
    pl    = TEN_ONE - PLW'(15) * PLW'(u3) + PLW'(6) * PLW'(x2v);
    h3p   = h2_5 * h5;
    d6    = h3_6 * pfit_pkg::DIV6_MUL;
    vt    = Q_ONE - (VW+1)'(h6) + (VW+1)'(h2_6 >> 1)
            + (VW+1)'(0) - (VW+1)'(d6[D6W-1:pfit_pkg::DIV6_SH]);
    yt    = {1'b0, yq6} + HALF_Y;
    den2  = Q_ONE + {1'b0, sv[SQN]};
    num2  = N2_TOP + N2W'(den2 >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      for (int k = 0; k <= SQN; k++) sv_vld[k] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
      sv_vld[0] <= v6;
      for (int k = 1; k <= SQN; k++) sv_vld[k] <= sv_vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x_in; u1 <= ux; d1 <= dd[UW-1:0]; b1 <= below;

      x2 <= x1; u2 <= u1; b2 <= b1;
      p2   <= {steep, 1'b0} * d1;
      sqx2 <= u1 * u1;

      x3 <= x2; u3 <= u2; b3 <= b2;
      h3r <= hs[HW-1:0];
      x2v <= x2t[F +: UW];

      x4 <= x3; b4 <= b3; h4 <= h3r;
      hh4   <= h3r * h3r;
      x3q   <= x2v * u3;
      poly4 <= pl;

      x5 <= x4; b5 <= b4; h5 <= h4;
      h2_5  <= hh4[Q +: H2W];
      x3v   <= x3t[F +: UW];
      poly5 <= poly4;

      x6 <= x5; b6 <= b5; h6 <= h5; h2_6 <= h2_5;
      h3_6 <= h3p[Q +: H3W];
      yq6  <= x3v * poly5;

      // series for exp(-a/4096) and the quintic rounding
      sv[0]  <= vt[VW-1:0];
      sb[0]  <= b6;
      sx[0]  <= x6;
      sqy[0] <= QYW'({1'b0, yt[F +: UW]}) - HALF_Q;

      // twelve squarings take exp(-a/4096) to exp(-a)
      for (int k = 1; k <= SQN; k++) begin
        sv[k]  <= VW'(((2*VW)'(sv[k-1]) * (2*VW)'(sv[k-1]) + Q_RND) >> Q);
        sb[k]  <= sb[k-1];
        sx[k]  <= sx[k-1];
        sqy[k] <= sqy[k-1];
      end
    end
  end

  pfit_div #(
    .NUM_W  (N2W),
    .DEN_W  (VW + 1),
    .SIDE_W (SDW),
    .STEP_N (pfit_pkg::DIV_STEP)
  ) u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sv_vld[SQN]),
    .num       (num2),
    .den       (den2),
    .side      ({sb[SQN], sx[SQN], sqy[SQN]}),
    .out_valid (dv_out),
    .quo       (quo2),
    .side_out  (side2)
  );

  assign r         = quo2[UW-1:0];
  assign out_valid = dv_out;
  assign x_out     = side2[QYW +: XW];
  assign qy_out    = side2[QYW-1:0];
  assign tanh_out  = side2[SDW-1] ? ONE_U - r : r;

endmodule

>>> src/phase_field_interpolation_table.sv
// Top level of the phase field interpolation table.
//
//  channel | direction | handshake              | payload
//  s_*     | in        | s_tvalid / s_tready    | s_tdata: grid_index
//  m_*     | out       | m_tvalid / m_tready    | m_tdata: value, m_tuser: mode_error
//  cfg_*   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle while the output is not stalled. A request passes the
// position divider, the function stages, the twelve squaring stages, the reciprocal
// divider and the output register; both dividers are 4-bit-per-stage. Reset clears
// valid bits and loads register defaults; config is live.
// While a result waits on m_tready the whole pipeline holds.
`include "phase_field_interpolation_table_macros.svh"
module phase_field_interpolation_table #(
  parameter int GRID_MAX  = pfit_pkg::GRID_MAX_DEF,
  parameter int FRAC_BITS = pfit_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pfit_pkg::IN_TDATA_W-1:0]     s_tdata,   // [12:0] grid_index
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pfit_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [18:0] value
  output logic                                m_tuser,   // [0] mode_error
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfit_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfit_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int F     = FRAC_BITS;
  localparam int IW    = pfit_pkg::IDX_W;
  localparam int GW    = pfit_pkg::GRID_W;
  localparam int NUM1W = IW + F;
  localparam int XW    = IW + F + 1;
  localparam int YW    = XW + 1;
  localparam int QYW   = F + 2;
  localparam int UW    = F + 1;
  localparam int VLW   = pfit_pkg::VALUE_W;

  localparam logic [GW:0] GMAX_C = (GRID_MAX > 2047) ? (GW+1)'(2047) : (GW+1)'(GRID_MAX);
  localparam logic signed [XW-1:0] ONE_X  = XW'(1) << F;
  localparam logic signed [YW-1:0] ONE_Y  = YW'(1) << F;
  localparam logic signed [YW-1:0] HALF_Y = YW'(1) << (F - 1);
  localparam logic signed [YW-1:0] VMAX_Y = YW'((1 << (VLW - 1)) - 1);
  localparam logic signed [YW-1:0] VMIN_Y = -VMAX_Y - YW'(1);

  logic [GW-1:0]                 grid_r;
  logic [pfit_pkg::MODE_W-1:0]   mode_r;
  logic [pfit_pkg::STEEP_W-1:0]  steep_r;
  logic signed [pfit_pkg::OFFS_W-1:0] offs_r;

  logic                 en;
  logic signed [IW-1:0] idx;
  logic [IW-1:0]        mag;
  logic [GW-1:0]        g_eff;
  logic [NUM1W-1:0]     num1, q1;
  logic                 d1_vld, d1_sign;
  logic signed [XW-1:0] x_pos;
  logic                 fn_vld;
  logic signed [XW-1:0] fx;
  logic signed [QYW-1:0] fqy;
  logic [UW-1:0]        ftanh;
  logic signed [YW-1:0] y;
  logic                 err;
  logic                 lt0, gt1;

  logic                 m_valid;
  logic signed [VLW-1:0] value_r;
  logic                 err_r;
  logic                 mode_ok;
  logic signed [YW-1:0] value_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_r  <= pfit_pkg::GRID_RST;
      mode_r  <= pfit_pkg::MODE_RST;
      steep_r <= pfit_pkg::STEEP_RST;
      offs_r  <= pfit_pkg::OFFS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pfit_pkg::REG_GRID:   grid_r  <= cfg_data[GW-1:0];
        pfit_pkg::REG_MODE:   mode_r  <= cfg_data[pfit_pkg::MODE_W-1:0];
        pfit_pkg::REG_STEEP:  steep_r <= cfg_data[pfit_pkg::STEEP_W-1:0];
        pfit_pkg::REG_OFFSET: offs_r  <= cfg_data[pfit_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !m_valid || m_tready;
  assign s_tready = en;

  always_comb begin
    idx = s_tdata[IW-1:0];
    mag = idx[IW-1] ? IW'(-idx) : IW'(idx);
    if (grid_r == '0) begin
      g_eff = GW'(1);
    end else if ({1'b0, grid_r} > GMAX_C) begin
      g_eff = GMAX_C[GW-1:0];
    end else begin
      g_eff = grid_r;
    end
    num1 = (NUM1W'(mag) << F) + NUM1W'(g_eff >> 1);
  end

  pfit_div #(
    .NUM_W  (NUM1W),
    .DEN_W  (GW),
    .SIDE_W (1),
    .STEP_N (pfit_pkg::DIV_STEP)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .num       (num1),
    .den       (g_eff),
    .side      (idx[IW-1]),
    .out_valid (d1_vld),
    .quo       (q1),
    .side_out  (d1_sign)
  );

  assign x_pos = d1_sign ? -$signed({1'b0, q1}) : $signed({1'b0, q1});

  pfit_fn #(
    .FRAC_BITS (F)
  ) u_fn (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d1_vld),
    .x_in      (x_pos),
    .steep     (steep_r),
    .out_valid (fn_vld),
    .x_out     (fx),
    .qy_out    (fqy),
    .tanh_out  (ftanh)
  );

  always_comb begin
    lt0 = fx[XW-1];
    gt1 = fx > ONE_X;
    err = 1'b0;
    case (mode_r)
      pfit_pkg::MODE_TANH: begin
        if (lt0) y = '0;
        else if (gt1) y = ONE_Y;
        else y = $signed(YW'(ftanh));
      end
      pfit_pkg::MODE_IDENT, pfit_pkg::MODE_IDENT2: begin
        y = YW'(fx);
      end
      pfit_pkg::MODE_OFFSET: begin
        y = YW'(fx) - YW'(offs_r);
      end
      pfit_pkg::MODE_QUINTIC: begin
        if (lt0) y = -HALF_Y;
        else if (gt1) y = HALF_Y;
        else y = YW'(fqy);
      end
      default: begin
        err = 1'b1;
        y   = '0;
      end
    endcase
    if (y < VMIN_Y) y = VMIN_Y;
    if (y > VMAX_Y) y = VMAX_Y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= fn_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= y[VLW-1:0];
      err_r   <= err;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {{(pfit_pkg::OUT_TDATA_W - VLW){1'b0}}, value_r};
  assign m_tuser  = err_r;

  assign mode_ok = mode_r inside {pfit_pkg::MODE_TANH, pfit_pkg::MODE_IDENT,
                                  pfit_pkg::MODE_OFFSET, pfit_pkg::MODE_QUINTIC,
                                  pfit_pkg::MODE_IDENT2};
  assign value_y = YW'(value_r);

  `PFIT_ASSERT_IMP(a_err_zero, clk, rst, m_valid && err_r, value_r == '0)
  `PFIT_ASSERT_ALW(a_err_mode, clk, rst, !m_valid || (err_r == !mode_ok))
  `PFIT_ASSERT_IMP(a_tanh_rng, clk, rst, m_valid && mode_r == pfit_pkg::MODE_TANH, !value_y[YW-1] && value_y <= ONE_Y)
  `PFIT_ASSERT_IMP(a_quin_rng, clk, rst, m_valid && mode_r == pfit_pkg::MODE_QUINTIC, value_y >= -HALF_Y && value_y <= HALF_Y)

endmodule
